// ----- hw/rtl/drs_pkg.sv -----
// Shared types and constants for the delimited record splitter.
// No dependencies; imported by every module of the block.
package drs_pkg;

    localparam int MAX_DELIM_DEF   = 8;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int DELIM_W   = 64;
    localparam int DELIM_CHARS = 8;
    localparam int CHAR_W    = 8;
    localparam int LEN_BITS  = 4;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = CFG_IDX_W'(1);

    localparam logic [DELIM_W-1:0]  DELIM_RESET = DELIM_W'(10);
    localparam logic [LEN_BITS-1:0] LEN_RESET   = LEN_BITS'(1);

    typedef struct packed {
        logic advance;
        logic match;
        logic last;
    } step_t;

endpackage

// ----- hw/rtl/drs_cell.sv -----
// One window cell: holds one recent byte and compares the byte it takes in.
// Depends on drs_pkg.
module drs_cell
    import drs_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                clear,
    input  logic [CHAR_W-1:0]   din,
    input  logic [LEN_BITS-1:0] len,
    input  logic [DELIM_W-1:0]  delim,
    output logic [CHAR_W-1:0]   dout,
    output logic                hit
);

    localparam logic [LEN_BITS-1:0] POS = LEN_BITS'(IDX);

    logic [CHAR_W-1:0]   byte_reg;
    logic [CHAR_W-1:0]   byte_next;
    logic [LEN_BITS-1:0] sel;
    logic [CHAR_W-1:0]   want;

    always_comb
    begin
        sel  = len - LEN_BITS'(1) - POS;
        want = delim[sel[2:0]*CHAR_W +: CHAR_W];
        hit  = (len <= POS) || (din == want);
    end

    always_comb
    begin
        byte_next = byte_reg;
        if (advance)
        begin
            byte_next = clear ? '0 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

// ----- hw/rtl/drs_counter.sv -----
// Byte offset, record start and overflow tracking for one text.
// Depends on drs_pkg.
module drs_counter
    import drs_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  step_t                  step,
    input  logic [LEN_BITS-1:0]    len,
    output logic [OFFSET_BITS-1:0] rec_start,
    output logic [OFFSET_BITS-1:0] rec_stop,
    output logic                   rec_over
);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] start_next;
    logic                   over_reg;
    logic                   over_next;
    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] len_w;
    logic                   sat;

    always_comb
    begin
        sat       = (offset_reg == OFFSET_MAX);
        nxt       = sat ? OFFSET_MAX : offset_reg + OFFSET_BITS'(1);
        len_w     = OFFSET_BITS'(len);
        rec_over  = over_reg | sat;
        rec_start = start_reg;
        if (step.match)
        begin
            rec_stop = (nxt >= len_w) ? nxt - len_w : '0;
        end
        else
        begin
            rec_stop = nxt;
        end
    end

    always_comb
    begin
        offset_next = offset_reg;
        start_next  = start_reg;
        over_next   = over_reg;
        if (step.advance)
        begin
            if (step.last)
            begin
                offset_next = '0;
                start_next  = '0;
                over_next   = 1'b0;
            end
            else
            begin
                offset_next = nxt;
                over_next   = rec_over;
                if (step.match)
                begin
                    start_next = nxt;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            start_reg  <= '0;
            over_reg   <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            start_reg  <= start_next;
            over_reg   <= over_next;
        end
    end

endmodule

// ----- hw/rtl/delimited_record_splitter_core.sv -----
// Top level of the delimited record splitter: window cells, counters, output register.
// Depends on drs_pkg, drs_cell, drs_counter.
//
//  channel   direction  handshake                 payload
//  text      in         text_valid / text_stall   text_byte, is_last
//  record    out        record_valid / record_stall  record_start, record_length,
//                                                 is_last_record, offset_overflow
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One byte per cycle unless stalled; a record appears the cycle after its ending byte.
// The window compare and the offset update both finish in the accepting cycle.
// The output register lets a new byte in while a record waits, unless it is stalled.
// Reset clears window, counters and record_valid; the delimiter returns to line feed.
// Text stalls only while a record is held under record_stall.
module delimited_record_splitter_core
    import drs_pkg::*;
#(
    parameter int MAX_DELIM   = MAX_DELIM_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  logic [CHAR_W-1:0]    text_byte,
    input  logic                 is_last,
    output logic                 record_valid,
    input  logic                 record_stall,
    output logic [OUT_W-1:0]     record_start,
    output logic [OUT_W-1:0]     record_length,
    output logic                 is_last_record,
    output logic                 offset_overflow,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELIM_W-1:0]   cfg_data
);

    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_DELIM);

    logic [DELIM_W-1:0]     delim_reg;
    logic [DELIM_W-1:0]     delim_next;
    logic [LEN_BITS-1:0]    dlen_reg;
    logic [LEN_BITS-1:0]    dlen_next;
    logic [LEN_BITS-1:0]    since_reg;
    logic [LEN_BITS-1:0]    since_next;
    logic [LEN_BITS-1:0]    since_inc;
    logic [LEN_BITS-1:0]    len;
    logic                   advance;
    logic                   match;
    step_t                  step;
    logic [CHAR_W-1:0]      win [MAX_DELIM];
    logic [CHAR_W-1:0]      feed [MAX_DELIM];
    logic [MAX_DELIM-1:0]   hits;
    logic [OFFSET_BITS-1:0] rec_start;
    logic [OFFSET_BITS-1:0] rec_stop;
    logic                   rec_over;

    logic                   valid_reg;
    logic                   valid_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] start_next;
    logic [OFFSET_BITS-1:0] stop_reg;
    logic [OFFSET_BITS-1:0] stop_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   over_reg;
    logic                   over_next;
    logic [OFFSET_BITS-1:0] span;
    logic [OFFSET_BITS+OUT_W-1:0] start_ext;
    logic [OFFSET_BITS+OUT_W-1:0] span_ext;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        delim_next = delim_reg;
        dlen_next  = dlen_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_DELIM_BYTES)
            begin
                delim_next = cfg_data;
            end
            else if (cfg_index == REG_DELIM_LENGTH)
            begin
                dlen_next = cfg_data[LEN_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        priority if (dlen_reg == '0)
        begin
            len = LEN_BITS'(1);
        end
        else if (dlen_reg > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        else
        begin
            len = dlen_reg;
        end
    end

    assign text_stall = valid_reg && record_stall;
    assign advance    = text_valid && !text_stall;

    genvar k;
    generate
        for (k = 0; k < MAX_DELIM; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign feed[k] = text_byte;
            end
            else
            begin : g_link
                assign feed[k] = win[k-1];
            end
            drs_cell #(
                .IDX (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .clear   (is_last),
                .din     (feed[k]),
                .len     (len),
                .delim   (delim_reg),
                .dout    (win[k]),
                .hit     (hits[k])
            );
        end
    endgenerate

    always_comb
    begin
        since_inc  = (since_reg < LEN_MAX) ? since_reg + LEN_BITS'(1) : since_reg;
        match      = (since_inc >= len) && (&hits);
        since_next = since_reg;
        if (advance)
        begin
            since_next = (is_last || match) ? '0 : since_inc;
        end
        step.advance = advance;
        step.match   = match;
        step.last    = is_last;
    end

    drs_counter #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .len       (len),
        .rec_start (rec_start),
        .rec_stop  (rec_stop),
        .rec_over  (rec_over)
    );

    always_comb
    begin
        valid_next = valid_reg && record_stall;
        start_next = start_reg;
        stop_next  = stop_reg;
        last_next  = last_reg;
        over_next  = over_reg;
        if (advance && (match || is_last))
        begin
            valid_next = 1'b1;
            start_next = rec_start;
            stop_next  = rec_stop;
            last_next  = is_last;
            over_next  = rec_over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
            dlen_reg  <= LEN_RESET;
            since_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            delim_reg <= delim_next;
            dlen_reg  <= dlen_next;
            since_reg <= since_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        stop_reg  <= stop_next;
        last_reg  <= last_next;
        over_reg  <= over_next;
    end

    always_comb
    begin
        span      = (stop_reg >= start_reg) ? stop_reg - start_reg : '0;
        start_ext = {{OUT_W{1'b0}}, start_reg};
        span_ext  = {{OUT_W{1'b0}}, span};
    end

    assign record_valid    = valid_reg;
    assign record_start    = start_ext[OUT_W-1:0];
    assign record_length   = span_ext[OUT_W-1:0];
    assign is_last_record  = last_reg;
    assign offset_overflow = over_reg;

endmodule

// ----- hw/rtl/drs_checker.sv -----
// Port-level checks for the delimited record splitter, bound to the top level.
// Depends on drs_pkg and delimited_record_splitter_core.
module drs_checker
    import drs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 text_valid,
    input logic                 text_stall,
    input logic                 is_last,
    input logic                 record_valid,
    input logic                 record_stall,
    input logic [OUT_W-1:0]     record_start,
    input logic [OUT_W-1:0]     record_length,
    input logic                 is_last_record
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && record_stall |=>
            record_valid && $stable(record_start) && $stable(record_length))
        else $error("stalled record changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> record_valid && record_stall)
        else $error("text stalled without a held record");

    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall && is_last |=> record_valid && is_last_record)
        else $error("final byte gave no last record");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !$past(record_valid) |-> $past(text_valid && !text_stall))
        else $error("record without an accepted byte");

endmodule

bind delimited_record_splitter_core drs_checker u_drs_checker (.*);
